>>> design/cbd_pkg.sv
// cbd_pkg: shared types, widths, status codes and character constants
// for the chunked body deframer; no dependencies
`default_nettype none

package cbd_pkg;

    localparam int CHUNK_SIZE_BITS = 32;
    localparam int LENGTH_BITS     = 48;
    localparam int CFG_DATA_BITS   = 48;
    localparam int CFG_INDEX_BITS  = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEN_CHECK_EN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_LEN = 2'd1;

    // status codes
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE = 3'd2;
    localparam logic [2:0] ST_BAD_TERM = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic                   out_valid;
        logic [7:0]             out_byte;
        logic [2:0]             status;
        logic [LENGTH_BITS-1:0] decoded_length;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.value = 4'(c - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> design/cbd_in_stage.sv
// cbd_in_stage: input register that holds one raw word for the parser
// depends on cbd_pkg
`default_nettype none

module cbd_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire cbd_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               item_valid,
    output cbd_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    cbd_pkg::item_t item_reg;
    logic           accept;

    // full and not draining this cycle
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> design/cbd_parser.sv
// cbd_parser: framing state and the per-word step that strips chunk
// framing, counts payload and latches status; depends on cbd_pkg
`default_nettype none

module cbd_parser (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [cbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [cbd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                 advance,
    input  wire cbd_pkg::item_t                       item,
    output cbd_pkg::result_t                          result
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_TERM_CR,
        PH_TERM_LF,
        PH_TRAILER,
        PH_STOP
    } phase_t;

    localparam int CSB = cbd_pkg::CHUNK_SIZE_BITS;
    localparam int LB  = cbd_pkg::LENGTH_BITS;

    phase_t           phase_reg, phase_next;
    logic [CSB-1:0]   remain_reg, remain_next;
    logic [CSB-1:0]   accum_reg, accum_next;
    logic             digits_reg, digits_next;
    logic             ext_reg, ext_next;
    logic             pcr_reg, pcr_next;
    logic             nonempty_reg, nonempty_next;
    logic [LB-1:0]    count_reg, count_next;
    logic [2:0]       status_reg, status_next;
    logic             len_chk_reg;
    logic [LB-1:0]    exp_len_reg;

    logic             emit;
    logic [7:0]       c;
    cbd_pkg::hex_t    hx;

    assign c  = item.in_byte;
    assign hx = cbd_pkg::hex_decode(c);

    always_comb
    begin
        phase_next    = phase_reg;
        remain_next   = remain_reg;
        accum_next    = accum_reg;
        digits_next   = digits_reg;
        ext_next      = ext_reg;
        pcr_next      = pcr_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        emit          = 1'b0;

        case (phase_reg)
            PH_SIZE:
            begin
                if (c == cbd_pkg::CH_LF)
                begin
                    if (!digits_reg)
                    begin
                        phase_next  = PH_STOP;
                        status_next = cbd_pkg::ST_BAD_SIZE;
                    end
                    else
                    begin
                        remain_next   = accum_reg;
                        phase_next    = (accum_reg == '0) ? PH_TRAILER : PH_DATA;
                        accum_next    = '0;
                        digits_next   = 1'b0;
                        ext_next      = 1'b0;
                        pcr_next      = 1'b0;
                        nonempty_next = 1'b0;
                    end
                end
                else if (ext_reg)
                begin
                    // extension text is skipped up to the line feed
                end
                else if (pcr_reg)
                begin
                    phase_next  = PH_STOP;
                    status_next = cbd_pkg::ST_BAD_SIZE;
                end
                else if (c == cbd_pkg::CH_CR)
                begin
                    pcr_next = 1'b1;
                end
                else if (c == cbd_pkg::CH_SEMI)
                begin
                    ext_next = 1'b1;
                end
                else if (!hx.ok || (accum_reg[CSB-1 -: 4] != 4'd0))
                begin
                    // not hex, or one more digit would overflow
                    phase_next  = PH_STOP;
                    status_next = cbd_pkg::ST_BAD_SIZE;
                end
                else
                begin
                    accum_next  = {accum_reg[CSB-5:0], hx.value};
                    digits_next = 1'b1;
                end
            end
            PH_DATA:
            begin
                emit        = 1'b1;
                count_next  = count_reg + LB'(1);
                remain_next = remain_reg - CSB'(1);
                if (remain_reg == CSB'(1))
                begin
                    phase_next = PH_TERM_CR;
                end
            end
            PH_TERM_CR:
            begin
                if (c == cbd_pkg::CH_CR)
                begin
                    phase_next = PH_TERM_LF;
                end
                else
                begin
                    phase_next  = PH_STOP;
                    status_next = cbd_pkg::ST_BAD_TERM;
                end
            end
            PH_TERM_LF:
            begin
                if (c == cbd_pkg::CH_LF)
                begin
                    phase_next    = PH_SIZE;
                    accum_next    = '0;
                    digits_next   = 1'b0;
                    ext_next      = 1'b0;
                    pcr_next      = 1'b0;
                    nonempty_next = 1'b0;
                end
                else
                begin
                    phase_next  = PH_STOP;
                    status_next = cbd_pkg::ST_BAD_TERM;
                end
            end
            PH_TRAILER:
            begin
                if (c == cbd_pkg::CH_LF)
                begin
                    if (!nonempty_reg)
                    begin
                        phase_next = PH_STOP;
                        if (len_chk_reg && (exp_len_reg != count_reg))
                        begin
                            status_next = cbd_pkg::ST_MISMATCH;
                        end
                        else
                        begin
                            status_next = cbd_pkg::ST_DONE;
                        end
                    end
                    else
                    begin
                        accum_next    = '0;
                        digits_next   = 1'b0;
                        ext_next      = 1'b0;
                        pcr_next      = 1'b0;
                        nonempty_next = 1'b0;
                    end
                end
                else if (c == cbd_pkg::CH_CR)
                begin
                    // a second cr makes the line nonempty
                    if (pcr_reg)
                    begin
                        nonempty_next = 1'b1;
                    end
                    pcr_next = 1'b1;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    pcr_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (item.in_last && (phase_next != PH_STOP))
        begin
            phase_next  = PH_STOP;
            status_next = cbd_pkg::ST_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIZE;
            remain_reg   <= '0;
            accum_reg    <= '0;
            digits_reg   <= 1'b0;
            ext_reg      <= 1'b0;
            pcr_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            count_reg    <= '0;
            status_reg   <= cbd_pkg::ST_RUN;
            len_chk_reg  <= 1'b0;
            exp_len_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg    <= phase_next;
                remain_reg   <= remain_next;
                accum_reg    <= accum_next;
                digits_reg   <= digits_next;
                ext_reg      <= ext_next;
                pcr_reg      <= pcr_next;
                nonempty_reg <= nonempty_next;
                count_reg    <= count_next;
                status_reg   <= status_next;
            end
            if (cfg_we && (cfg_index == cbd_pkg::CFG_LEN_CHECK_EN))
            begin
                len_chk_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == cbd_pkg::CFG_EXPECTED_LEN))
            begin
                exp_len_reg <= cfg_data[LB-1:0];
            end
        end
    end

    always_comb
    begin
        result.out_valid      = emit;
        result.out_byte       = emit ? c : 8'd0;
        result.status         = status_next;
        result.decoded_length = count_next;
    end

endmodule

`default_nettype wire

>>> design/cbd_out_stage.sv
// cbd_out_stage: result register toward the receiver, holds under stall
// depends on cbd_pkg
`default_nettype none

module cbd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load_valid,
    input  wire cbd_pkg::result_t load_result,
    output logic                  ready,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output cbd_pkg::result_t      res
);

    logic             valid_reg;
    logic             valid_next;
    cbd_pkg::result_t res_reg;

    // room when empty or when the held word leaves this cycle
    assign ready = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load_valid)
        begin
            res_reg <= load_result;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> design/chunked_body_deframer.sv
// chunked_body_deframer: top level, input register, parser and result register
// depends on cbd_pkg, cbd_in_stage, cbd_parser, cbd_out_stage
//
// usage:
//   input channel in_valid/in_stall carries one raw body byte per word with
//   in_last marking the final byte. every accepted word gives exactly one
//   result word on res_valid/res_stall: out_valid/out_byte (a payload byte,
//   out_byte zero when none), status and decoded_length after that byte.
//   throughput is one word per cycle while the receiver does not stall. a
//   word is registered in the input register, parsed there and loaded into
//   the result register when the parser step advances. the framing state
//   updates once per word, set by the single parser step.
//   when the receiver stalls the result register holds its word, the input
//   register still takes one more word, and in_stall rises once both hold.
//   once status leaves running, later bytes are taken and answered with the
//   same status and count and no payload. reset clears both stages, the
//   framing state and the configuration (length check off, expected length
//   zero). the user must write configuration through cfg_we/cfg_index/cfg_data
//   only while the block is idle; the block itself does not enforce this.
`default_nettype none

module chunked_body_deframer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [cbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [cbd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                in_last,
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output logic                                     out_valid,
    output logic [7:0]                               out_byte,
    output logic [2:0]                               status,
    output logic [cbd_pkg::LENGTH_BITS-1:0]          decoded_length
);

    cbd_pkg::item_t   in_item;
    cbd_pkg::item_t   item;
    cbd_pkg::result_t step_result;
    cbd_pkg::result_t res;
    logic             item_valid;
    logic             out_ready;
    logic             advance;

    assign in_item.in_byte = in_byte;
    assign in_item.in_last = in_last;
    assign advance         = item_valid && out_ready;

    cbd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cbd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (step_result)
    );

    cbd_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (item_valid),
        .load_result (step_result),
        .ready       (out_ready),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

    assign out_valid      = res.out_valid;
    assign out_byte       = res.out_byte;
    assign status         = res.status;
    assign decoded_length = res.decoded_length;

endmodule

`default_nettype wire

>>> design/cbd_checker.sv
// cbd_checker: port-level assertions for chunked_body_deframer, bound to it
// depends on cbd_pkg
`default_nettype none

module cbd_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic [7:0]                          in_byte,
    input wire logic                                res_valid,
    input wire logic                                res_stall,
    input wire logic                                out_valid,
    input wire logic [7:0]                          out_byte,
    input wire logic [2:0]                          status,
    input wire logic [cbd_pkg::LENGTH_BITS-1:0]     decoded_length
);

    // stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(in_byte)))
        else $error("input word changed under stall");

    // payload only while running, or on the byte that hits truncation
    a_payload_running: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid) |->
            (status == cbd_pkg::ST_RUN || status == cbd_pkg::ST_TRUNC))
        else $error("payload word with terminal status");

    // framing words carry a zero byte
    a_no_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (out_byte == 8'd0))
        else $error("nonzero byte without payload");

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=>
            (res_valid && $stable(out_byte) && $stable(status)
             && $stable(decoded_length) && $stable(out_valid)))
        else $error("result word changed under stall");

    // a terminal status never goes back to running
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !out_valid && status != cbd_pkg::ST_RUN)
            |=> (!res_valid || status != cbd_pkg::ST_RUN))
        else $error("status left a terminal code");

endmodule

bind chunked_body_deframer cbd_checker u_cbd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .status         (status),
    .decoded_length (decoded_length)
);

`default_nettype wire
